### rtl/core/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int RES_W = 64;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_ERROR    = 2'd2
  } status_t;

endpackage

### rtl/core/rau_if.sv
// ----------------------------------------------------------------------------
// rau_in_if / rau_out_if
// Valid/ready channels carrying operand and result transfers.
// ----------------------------------------------------------------------------
interface rau_in_if #(parameter int OPERAND_WIDTH = 32);
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic [OPERAND_WIDTH-1:0] a_numerator;
  logic [OPERAND_WIDTH-1:0] a_denominator;
  logic                     a_negative;
  logic [OPERAND_WIDTH-1:0] b_numerator;
  logic [OPERAND_WIDTH-1:0] b_denominator;
  logic                     b_negative;
  modport source (output valid, kind, a_numerator, a_denominator, a_negative,
                  b_numerator, b_denominator, b_negative, input ready);
  modport sink   (input valid, kind, a_numerator, a_denominator, a_negative,
                  b_numerator, b_denominator, b_negative, output ready);
endinterface

interface rau_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_numerator;
  logic [63:0] result_denominator;
  logic        result_negative;
  logic [1:0]  status;
  modport source (output valid, result_numerator, result_denominator,
                  result_negative, status, input ready);
  modport sink   (input valid, result_numerator, result_denominator,
                  result_negative, status, output ready);
endinterface

### rtl/core/rational_arithmetic_unit.sv
// Sequencing: error items go straight to S_OUT; other items run the shared
// 64-bit restoring divider once per Euclid step plus two quotient divisions
// to reduce the result and, for add/sub, two more to scale the operands.
// Throughput: one item at a time; the next transfer is taken after the result
// leaves the sequencer for the output register.
// Reset: synchronous active-high rst clears sequencer and output valid.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Sequenced rational add/sub/mul/div with shared multiplier and divider.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst,
  rau_in_if.sink   in_ch,
  rau_out_if.source out_ch
);

  localparam int W = OPERAND_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_COMB, S_GCD, S_GSTEP, S_DIV, S_QA, S_QB, S_RN, S_RD, S_OUT
  } state_t;

  state_t         state, ret;
  logic           addsub, is_div, red;
  logic [1:0]     mstep;
  logic [W-1:0]   an, ad, bn, bd, qa, qb;
  logic           aneg, bneg, rneg;
  logic [RES_W-1:0] num, den, sb, gx, gy;
  status_t        rstat;
  logic [RES_W-1:0] quo, rem, dvs;
  logic [5:0]     cnt;

  logic [W-1:0]     ma, mb;
  logic [2*W-1:0]   prod;
  logic [RES_W:0]   rem_sh, rem_sub, sum;
  logic [RES_W-1:0] nn;
  logic             nneg;
  logic             ovf;

  always_comb begin
    ma = an;
    mb = bn;
    if (addsub) begin
      case (mstep)
        2'd0: begin ma = qa; mb = bd; end
        2'd1: begin ma = an; mb = qb; end
        default: begin ma = bn; mb = qa; end
      endcase
    end else begin
      case (mstep)
        2'd0: begin ma = an; mb = is_div ? bd : bn; end
        default: begin ma = ad; mb = is_div ? bn : bd; end
      endcase
    end
  end

  assign prod    = ma * mb;
  assign rem_sh  = {rem, quo[RES_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign sum     = {1'b0, num} + {1'b0, sb};

  always_comb begin
    ovf  = 1'b0;
    nn   = '0;
    nneg = 1'b0;
    if (aneg == bneg) begin
      ovf  = sum[RES_W];
      nn   = sum[RES_W-1:0];
      nneg = aneg;
    end else if (num > sb) begin
      nn   = num - sb;
      nneg = aneg;
    end else if (sb > num) begin
      nn   = sb - num;
      nneg = bneg;
    end
  end

  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ret          <= S_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && state != S_OUT) out_ch.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            an     <= in_ch.a_numerator;
            ad     <= in_ch.a_denominator;
            bn     <= in_ch.b_numerator;
            bd     <= in_ch.b_denominator;
            aneg   <= in_ch.a_negative;
            bneg   <= in_ch.b_negative ^ (op_t'(in_ch.kind) == OP_SUB);
            addsub <= (op_t'(in_ch.kind) == OP_ADD) || (op_t'(in_ch.kind) == OP_SUB);
            is_div <= (op_t'(in_ch.kind) == OP_DIV);
            rneg   <= in_ch.a_negative ^ in_ch.b_negative;
            mstep  <= 2'd0;
            red    <= 1'b0;
            rstat  <= ST_OK;
            if (in_ch.a_denominator == '0 || in_ch.b_denominator == '0 ||
                (op_t'(in_ch.kind) == OP_DIV && in_ch.b_numerator == '0)) begin
              rstat <= ST_ERROR;
              state <= S_OUT;
            end else if ((op_t'(in_ch.kind) == OP_ADD) ||
                         (op_t'(in_ch.kind) == OP_SUB)) begin
              gx    <= RES_W'(in_ch.a_denominator);
              gy    <= RES_W'(in_ch.b_denominator);
              state <= S_GCD;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          mstep <= mstep + 2'd1;
          if (addsub) begin
            case (mstep)
              2'd0: den <= RES_W'(prod);
              2'd1: num <= RES_W'(prod);
              default: begin
                sb    <= RES_W'(prod);
                state <= S_COMB;
              end
            endcase
          end else if (mstep == 2'd0) begin
            num <= RES_W'(prod);
          end else begin
            den   <= RES_W'(prod);
            gx    <= num;
            gy    <= RES_W'(prod);
            red   <= 1'b1;
            state <= S_GCD;
          end
        end
        S_COMB: begin
          if (ovf) begin
            rstat <= ST_OVERFLOW;
            state <= S_OUT;
          end else begin
            num   <= nn;
            rneg  <= nneg;
            gx    <= nn;
            gy    <= den;
            red   <= 1'b1;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          cnt   <= '0;
          rem   <= '0;
          state <= S_DIV;
          if (gy != '0) begin
            quo <= gx;
            dvs <= gy;
            ret <= S_GSTEP;
          end else if (red) begin
            quo <= num;
            dvs <= gx;
            ret <= S_RN;
          end else begin
            quo <= RES_W'(ad);
            dvs <= gx;
            ret <= S_QA;
          end
        end
        S_GSTEP: begin
          gx    <= gy;
          gy    <= rem;
          state <= S_GCD;
        end
        S_DIV: begin
          if (rem_sub[RES_W]) begin
            rem <= rem_sh[RES_W-1:0];
            quo <= {quo[RES_W-2:0], 1'b0};
          end else begin
            rem <= rem_sub[RES_W-1:0];
            quo <= {quo[RES_W-2:0], 1'b1};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) state <= ret;
        end
        S_QA: begin
          qa    <= quo[W-1:0];
          quo   <= RES_W'(bd);
          dvs   <= gx;
          rem   <= '0;
          cnt   <= '0;
          ret   <= S_QB;
          state <= S_DIV;
        end
        S_QB: begin
          qb    <= quo[W-1:0];
          mstep <= 2'd0;
          state <= S_MUL;
        end
        S_RN: begin
          num   <= quo;
          quo   <= den;
          dvs   <= gx;
          rem   <= '0;
          cnt   <= '0;
          ret   <= S_RD;
          state <= S_DIV;
        end
        S_RD: begin
          den   <= quo;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid  <= 1'b1;
            out_ch.status <= rstat;
            if (rstat != ST_OK || num == '0) begin
              out_ch.result_numerator   <= '0;
              out_ch.result_denominator <= RES_W'(1);
              out_ch.result_negative    <= 1'b0;
            end else begin
              out_ch.result_numerator   <= num;
              out_ch.result_denominator <= den;
              out_ch.result_negative    <= rneg;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks of the rational arithmetic unit, bound to rational_arithmetic_unit.
// ----------------------------------------------------------------------------
module rau_checker import rau_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] result_numerator,
  input logic [63:0] result_denominator,
  input logic        result_negative,
  input logic [1:0]  status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |->
      result_numerator == 64'd0 && result_denominator == 64'd1 && !result_negative)
    else $error("error result fields not cleared");

  a_zero_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_numerator == 64'd0 |->
      result_denominator == 64'd1 && !result_negative)
    else $error("zero result not +0/1");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("transfer taken while busy");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk                (clk),
  .rst                (rst),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .result_numerator   (out_ch.result_numerator),
  .result_denominator (out_ch.result_denominator),
  .result_negative    (out_ch.result_negative),
  .status             (out_ch.status)
);

### bench/rational_arithmetic_unit_test.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_test
// Drives operand transfers with random gaps and output stalls, predicts each
// reduced rational result and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_test;
  import rau_pkg::*;

  typedef struct {
    op_t         kind;
    logic [31:0] an, ad;
    logic        aneg;
    logic [31:0] bn, bd;
    logic        bneg;
  } operands_t;

  typedef struct {
    logic [63:0] num, den;
    logic        neg;
    status_t     status;
  } quotient_t;

  typedef struct {
    operands_t ops;
    logic      known;
    quotient_t res;
  } row_t;

  logic clk;
  logic rst;
  int   failures;

  rau_in_if  #(.OPERAND_WIDTH(32)) in_ch ();
  rau_out_if out_ch ();

  rational_arithmetic_unit #(.OPERAND_WIDTH(32)) DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  quotient_t pending_results[$];
  logic      rows_done;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #600000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [63:0] euclid(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic quotient_t reduce(logic [63:0] num, logic [63:0] den, logic neg,
                                       status_t st);
    quotient_t q;
    logic [63:0] g;
    if (st != ST_OK) begin
      q = '{64'd0, 64'd1, 1'b0, st};
    end else begin
      g = euclid(num, den);
      if (g != 0) begin
        num = num / g;
        den = den / g;
      end
      if (num == 0) begin
        den = 64'd1;
        neg = 1'b0;
      end
      q = '{num, den, neg, ST_OK};
    end
    return q;
  endfunction

  function automatic quotient_t predict_rational(operands_t o);
    logic [63:0] an, ad, bn, bd, g, lcm, sa, sb;
    logic [64:0] sum;
    logic        bneg;
    an = {32'd0, o.an};
    ad = {32'd0, o.ad};
    bn = {32'd0, o.bn};
    bd = {32'd0, o.bd};
    bneg = o.bneg;
    if (ad == 0 || bd == 0 || (o.kind == OP_DIV && bn == 0))
      return reduce(0, 1, 1'b0, ST_ERROR);
    if (o.kind == OP_MUL) return reduce(an * bn, ad * bd, o.aneg ^ bneg, ST_OK);
    if (o.kind == OP_DIV) return reduce(an * bd, ad * bn, o.aneg ^ bneg, ST_OK);
    if (o.kind == OP_SUB) bneg = ~bneg;
    g = euclid(ad, bd);
    lcm = (ad / g) * bd;
    sa = an * (lcm / ad);
    sb = bn * (lcm / bd);
    if (o.aneg == bneg) begin
      sum = {1'b0, sa} + {1'b0, sb};
      if (sum[64]) return reduce(0, 1, 1'b0, ST_OVERFLOW);
      return reduce(sum[63:0], lcm, o.aneg, ST_OK);
    end
    if (sa > sb) return reduce(sa - sb, lcm, o.aneg, ST_OK);
    if (sb > sa) return reduce(sb - sa, lcm, bneg, ST_OK);
    return reduce(0, 1, 1'b0, ST_OK);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 15);
      1: return $urandom_range(1, 1000);
      2: return $urandom_range(0, 65535);
      3: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic operands_t random_operands();
    operands_t o;
    o.kind = op_t'($urandom_range(0, 3));
    o.an = pick_value();
    o.bn = pick_value();
    o.ad = pick_value();
    o.bd = pick_value();
    if (o.ad == 0 && $urandom_range(0, 3) != 0) o.ad = 32'd1;
    if (o.bd == 0 && $urandom_range(0, 3) != 0) o.bd = 32'd1;
    if ($urandom_range(0, 9) == 0) begin
      o.bn = o.an;
      o.bd = o.ad;
    end
    o.aneg = $urandom_range(0, 1);
    o.bneg = $urandom_range(0, 1);
    return o;
  endfunction

  task automatic send(operands_t o);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= o.kind;
    in_ch.a_numerator   <= o.an;
    in_ch.a_denominator <= o.ad;
    in_ch.a_negative    <= o.aneg;
    in_ch.b_numerator   <= o.bn;
    in_ch.b_denominator <= o.bd;
    in_ch.b_negative    <= o.bneg;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_rational(o));
  endtask

  // Output side: random stalls, compare against oldest pending result
  initial begin
    quotient_t exp_r;
    int        stall;
    stall = 0;
    out_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing pending");
          failures++;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_ch.result_numerator !== exp_r.num) begin
            $error("result_numerator expected %0d got %0d", exp_r.num,
                   out_ch.result_numerator);
            failures++;
          end
          if (out_ch.result_denominator !== exp_r.den) begin
            $error("result_denominator expected %0d got %0d", exp_r.den,
                   out_ch.result_denominator);
            failures++;
          end
          if (out_ch.result_negative !== exp_r.neg) begin
            $error("result_negative expected %0b got %0b", exp_r.neg,
                   out_ch.result_negative);
            failures++;
          end
          if (out_ch.status !== exp_r.status) begin
            $error("status expected %0d got %0d", exp_r.status, out_ch.status);
            failures++;
          end
        end
      end
      if (stall > 0) stall--;
      else if ($urandom_range(0, 2) == 0) stall = pick_gap();
      out_ch.ready <= (stall == 0);
    end
  end

  initial begin
    row_t      rows[$];
    operands_t o;
    int        wait_cycles;
    failures = 0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.kind = OP_ADD;
    in_ch.a_numerator = '0;
    in_ch.a_denominator = '0;
    in_ch.a_negative = 1'b0;
    in_ch.b_numerator = '0;
    in_ch.b_denominator = '0;
    in_ch.b_negative = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    rows.push_back('{'{OP_ADD, 32'd1, 32'd2, 1'b0, 32'd1, 32'd3, 1'b0}, 1'b1,
                     '{64'd5, 64'd6, 1'b0, ST_OK}});
    rows.push_back('{'{OP_ADD, 32'd1, 32'd0, 1'b0, 32'd1, 32'd3, 1'b0}, 1'b1,
                     '{64'd0, 64'd1, 1'b0, ST_ERROR}});
    rows.push_back('{'{OP_MUL, 32'd1, 32'd2, 1'b1, 32'd1, 32'd0, 1'b1}, 1'b1,
                     '{64'd0, 64'd1, 1'b0, ST_ERROR}});
    rows.push_back('{'{OP_DIV, 32'd3, 32'd4, 1'b0, 32'd0, 32'd5, 1'b1}, 1'b1,
                     '{64'd0, 64'd1, 1'b0, ST_ERROR}});
    rows.push_back('{'{OP_SUB, 32'd7, 32'd9, 1'b1, 32'd7, 32'd9, 1'b1}, 1'b1,
                     '{64'd0, 64'd1, 1'b0, ST_OK}});
    rows.push_back('{'{OP_ADD, 32'd7, 32'd9, 1'b0, 32'd7, 32'd9, 1'b1}, 1'b1,
                     '{64'd0, 64'd1, 1'b0, ST_OK}});
    rows.push_back('{'{OP_MUL, 32'd0, 32'd5, 1'b1, 32'd3, 32'd7, 1'b0}, 1'b1,
                     '{64'd0, 64'd1, 1'b0, ST_OK}});
    rows.push_back('{'{OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
                       32'd1, 1'b0}, 1'b0, '{0, 0, 0, ST_OK}});
    rows.push_back('{'{OP_DIV, 32'hFFFF_FFFF, 32'd1, 1'b1, 32'd1, 32'hFFFF_FFFF,
                       1'b1}, 1'b0, '{0, 0, 0, ST_OK}});
    rows.push_back('{'{OP_ADD, 32'hFFFF_FFFF, 32'd1, 1'b0, 32'hFFFF_FFFF,
                       32'hFFFF_FFFE, 1'b0}, 1'b0, '{0, 0, 0, ST_OK}});
    rows.push_back('{'{OP_ADD, 32'hFFFF_FFFF, 32'd1, 1'b0, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 1'b0}, 1'b0, '{0, 0, 0, ST_OK}});
    rows.push_back('{'{OP_SUB, 32'hFFFF_FFFF, 32'hFFFF_FFFD, 1'b1, 32'hFFFF_FFFF,
                       32'hFFFF_FFFE, 1'b0}, 1'b0, '{0, 0, 0, ST_OK}});
    rows.push_back('{'{OP_SUB, 32'd1, 32'd3, 1'b0, 32'd1, 32'd2, 1'b0}, 1'b1,
                     '{64'd1, 64'd6, 1'b1, ST_OK}});
    rows.push_back('{'{OP_DIV, 32'd2, 32'd3, 1'b1, 32'd4, 32'd9, 1'b0}, 1'b1,
                     '{64'd3, 64'd2, 1'b1, ST_OK}});
    rows.push_back('{'{OP_ADD, 32'd0, 32'd0, 1'b1, 32'd0, 32'd0, 1'b1}, 1'b1,
                     '{64'd0, 64'd1, 1'b0, ST_ERROR}});

    foreach (rows[i]) begin
      if (rows[i].known && predict_rational(rows[i].ops) != rows[i].res) begin
        $error("table row %0d disagrees with prediction", i);
        failures++;
      end
      send(rows[i].ops);
    end

    repeat (1100) begin
      o = random_operands();
      send(o);
    end
    in_ch.valid <= 1'b0;

    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (100) @(posedge clk);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### rational_arithmetic_unit.f
rtl/core/rau_pkg.sv
rtl/core/rau_if.sv
rtl/core/rational_arithmetic_unit.sv
rtl/core/rau_checker.sv
bench/rational_arithmetic_unit_test.sv
